FILE: src/tbe_pkg.sv
// ----------------------------------------------------------------------------
// tbe_pkg
// Shared types, constants and helpers of the tape bytecode executor.
// ----------------------------------------------------------------------------
package tbe_pkg;

  localparam int TAPE_CELLS_DEF = 65536;
  localparam int CELL_BITS_DEF  = 32;
  localparam int PROG_DEPTH_DEF = 4096;

  localparam int PC_W       = 13;
  localparam int PTR_W      = 16;
  localparam int OPC_W      = 4;
  localparam int OPND_W     = 32;
  localparam int CHAR_W     = 9;
  localparam int CNT_W      = 16;
  localparam int IN_TDATA_W = 48;
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);

  localparam logic [PC_W-1:0]  PC_LIMIT  = 13'h1fff;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hffff;

  typedef enum logic [OPC_W-1:0] {
    OP_NOP     = 4'd0,
    OP_ADD     = 4'd1,
    OP_ADD_UP  = 4'd2,
    OP_ADD_DN  = 4'd3,
    OP_PTR_ADD = 4'd4,
    OP_IN      = 4'd5,
    OP_OUT     = 4'd6,
    OP_JZ      = 4'd7,
    OP_JNZ     = 4'd8,
    OP_SET     = 4'd9
  } opcode_t;

  // Result word; the last field sits in the lowest bits.
  typedef struct packed {
    logic             illegal;
    logic             halted;
    logic             zero_flag;
    logic [CNT_W-1:0] in_consume;
    logic [CNT_W-1:0] out_repeat;
    logic [7:0]       out_char;
    logic [PC_W-1:0]  next_pc;
  } res_t;

  localparam int OUT_TDATA_W = $bits(res_t);

  // Repeat or consume count: non-positive gives zero, large values saturate.
  function automatic logic [CNT_W-1:0] count_sat(logic signed [OPND_W-1:0] op);
    logic [CNT_W-1:0] c;
    if (op <= 0) begin
      c = '0;
    end else if (op > $signed({1'b0, COUNT_MAX})) begin
      c = COUNT_MAX;
    end else begin
      c = op[CNT_W-1:0];
    end
    return c;
  endfunction

  // Pointer modulo a constant tape size of at least 256 cells: the quotient
  // has at most eight bits, so eight restoring subtract steps suffice.
  function automatic logic [PTR_W-1:0] tape_mod(logic [PTR_W-1:0] p, int n);
    logic [PTR_W:0] r;
    r = {1'b0, p};
    for (int k = 7; k >= 0; k--) begin
      if (32'(r) >= (n << k)) begin
        r = (PTR_W+1)'(32'(r) - (n << k));
      end
    end
    return r[PTR_W-1:0];
  endfunction

endpackage

FILE: src/tbe_tape_store.sv
// ----------------------------------------------------------------------------
// tbe_tape_store
// Tape cell memory: one write and one read port, registered read data with
// same-address write forwarding, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module tbe_tape_store #(
  parameter int TAPE_CELLS = tbe_pkg::TAPE_CELLS_DEF,
  parameter int CELL_BITS  = tbe_pkg::CELL_BITS_DEF,
  localparam int IDX_W     = $clog2(TAPE_CELLS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [CELL_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [CELL_BITS-1:0] rd_data,
  output logic                 busy
);

  logic [CELL_BITS-1:0] mem [TAPE_CELLS];
  logic [CELL_BITS-1:0] rd_q_r;
  logic [CELL_BITS-1:0] fwd_data_r;
  logic                 fwd_r;
  logic                 busy_r, busy_nxt;
  logic [IDX_W-1:0]     clr_idx_r, clr_idx_nxt;

  always_comb begin
    busy_nxt    = busy_r;
    clr_idx_nxt = clr_idx_r;
    if (busy_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(TAPE_CELLS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the cell written in the same cycle returns the new value.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;
  assign busy    = busy_r;

endmodule

FILE: src/tape_bytecode_executor.sv
// ----------------------------------------------------------------------------
// tape_bytecode_executor
// Executes one tape-machine bytecode instruction per input word and returns
// one status word per instruction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | input     | in_tvalid / in_tready  | opcode, operand, in_char
//  out_    | output    | out_tvalid / out_tready| next_pc .. illegal
//  cfg_    | input     | cfg_wen                | program_length
//
//  Add-and-move and pointer add hold off the next input word until the
//  new cell comes back from the registered read of the tape memory.
//  After reset the tape is swept to zero with in_tready low. Results go
//  through a four-word queue, so input keeps flowing until four results
//  are waiting for out_tready.
// ----------------------------------------------------------------------------
module tape_bytecode_executor #(
  parameter int TAPE_CELLS = tbe_pkg::TAPE_CELLS_DEF,
  parameter int CELL_BITS  = tbe_pkg::CELL_BITS_DEF,
  parameter int PROG_DEPTH = tbe_pkg::PROG_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wen,
  input  logic [tbe_pkg::PC_W-1:0]           cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // opcode[3:0], operand[35:4], in_char[44:36], zero fill[47:45]
  input  logic [tbe_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // next_pc[12:0], out_char[20:13], out_repeat[36:21], in_consume[52:37],
  // zero_flag[53], halted[54], illegal[55]
  output logic [tbe_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  import tbe_pkg::*;

  localparam int  IDX_W      = $clog2(TAPE_CELLS);
  localparam bit  TAPE_POW2  = (TAPE_CELLS & (TAPE_CELLS - 1)) == 0;

  // Fields of the input word.
  logic [OPC_W-1:0]         opc;
  logic signed [OPND_W-1:0] operand;
  logic signed [CHAR_W-1:0] in_char;

  assign opc     = in_tdata[OPC_W-1:0];
  assign operand = in_tdata[OPC_W+OPND_W-1:OPC_W];
  assign in_char = in_tdata[OPC_W+OPND_W+CHAR_W-1:OPC_W+OPND_W];

  // Architectural state.
  logic [PC_W-1:0]      prog_len_r;
  logic [PC_W-1:0]      pc_r, pc_nxt;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CELL_BITS-1:0] cached_r, cached_nxt;
  logic                 dirty_r, dirty_nxt;

  // Load slot between execute and the result queue.
  logic s_valid_r, s_load_r, s_load_nxt;
  res_t s_res_r, s_res_nxt;

  // Result queue.
  res_t                oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_r, oq_rd_r;
  logic [OQ_PTR_W:0]   oq_cnt_r, oq_cnt_nxt;
  logic                push, pop;
  res_t                push_res;

  // Tape memory ports.
  logic                 wr_en, rd_en, mem_busy;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [CELL_BITS-1:0] wr_data, rd_data;

  logic            accept;
  logic [PC_W-1:0] act_len;

  assign act_len = (32'(prog_len_r) > PROG_DEPTH) ? PC_W'(PROG_DEPTH) : prog_len_r;

  assign in_tready = !mem_busy && !(s_valid_r && s_load_r)
                   && ((oq_cnt_r + (OQ_PTR_W+1)'(s_valid_r)) < (OQ_PTR_W+1)'(OQ_DEPTH));
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    logic [CELL_BITS-1:0] sum;
    logic [PTR_W-1:0]     new_ptr;
    logic signed [31:0]   ch32;
    logic signed [33:0]   tgt;
    logic                 taken;
    logic [CNT_W-1:0]     cnt;

    sum     = cached_r + operand[CELL_BITS-1:0];
    ch32    = 32'(in_char);
    tgt     = $signed({21'b0, pc_r}) + 34'(operand);
    cnt     = count_sat(operand);
    taken   = 1'b0;
    new_ptr = ptr_r;

    pc_nxt     = pc_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    cached_nxt = cached_r;
    dirty_nxt  = dirty_r;
    s_load_nxt = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = cached_r;
    rd_en      = 1'b0;

    s_res_nxt            = '0;
    s_res_nxt.next_pc    = pc_r;

    case (opcode_t'(opc))
      OP_ADD_UP:  new_ptr = ptr_r + 1'b1;
      OP_ADD_DN:  new_ptr = ptr_r - 1'b1;
      OP_PTR_ADD: new_ptr = ptr_r + operand[PTR_W-1:0];
      default:    new_ptr = ptr_r;
    endcase
    rd_addr = TAPE_POW2 ? new_ptr[IDX_W-1:0] : IDX_W'(tape_mod(new_ptr, TAPE_CELLS));

    if (accept && (pc_r < act_len)) begin
      pc_nxt = pc_r + 1'b1;
      case (opcode_t'(opc))
        OP_NOP: begin
        end
        OP_ADD: begin
          cached_nxt = sum;
          dirty_nxt  = 1'b1;
        end
        OP_ADD_UP, OP_ADD_DN, OP_PTR_ADD: begin
          if (opcode_t'(opc) != OP_PTR_ADD) begin
            wr_en   = 1'b1;
            wr_data = sum;
          end else begin
            wr_en   = dirty_r;
          end
          dirty_nxt  = 1'b0;
          ptr_nxt    = new_ptr;
          idx_nxt    = rd_addr;
          rd_en      = 1'b1;
          s_load_nxt = 1'b1;
        end
        OP_IN: begin
          s_res_nxt.in_consume = cnt;
          if (cnt != '0) begin
            cached_nxt = ch32[CELL_BITS-1:0];
          end
          dirty_nxt = 1'b1;
        end
        OP_OUT: begin
          s_res_nxt.out_repeat = cnt;
          s_res_nxt.out_char   = cached_r[7:0];
        end
        OP_JZ, OP_JNZ: begin
          taken = (opcode_t'(opc) == OP_JZ) ? (cached_r == '0) : (cached_r != '0);
          if (taken) begin
            pc_nxt = (tgt < 0 || tgt > $signed({21'b0, PC_LIMIT})) ? PC_LIMIT
                                                                   : tgt[PC_W-1:0];
          end
        end
        OP_SET: begin
          cached_nxt = operand[CELL_BITS-1:0];
          dirty_nxt  = 1'b1;
        end
        default: begin
          s_res_nxt.illegal = 1'b1;
          pc_nxt            = pc_r;
        end
      endcase
    end
    s_res_nxt.next_pc = pc_nxt;
    s_res_nxt.halted  = (pc_nxt >= act_len);

    // The load slot never overlaps an accept, so the loaded cell wins alone.
    if (s_valid_r && s_load_r) begin
      cached_nxt = rd_data;
    end
  end

  // Zero flag is settled in the load slot, once the current cell is known.
  always_comb begin
    push_res           = s_res_r;
    push_res.zero_flag = s_load_r ? (rd_data == '0) : (cached_r == '0);
  end

  assign push       = s_valid_r;
  assign pop        = out_tvalid && out_tready;
  assign oq_cnt_nxt = oq_cnt_r + (OQ_PTR_W+1)'(push) - (OQ_PTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
      pc_r       <= '0;
      ptr_r      <= '0;
      idx_r      <= '0;
      cached_r   <= '0;
      dirty_r    <= 1'b0;
      s_valid_r  <= 1'b0;
      s_load_r   <= 1'b0;
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_cnt_r   <= '0;
    end else begin
      if (cfg_wen) begin
        prog_len_r <= cfg_wdata;
      end
      pc_r      <= pc_nxt;
      ptr_r     <= ptr_nxt;
      idx_r     <= idx_nxt;
      cached_r  <= cached_nxt;
      dirty_r   <= dirty_nxt;
      s_valid_r <= accept;
      s_load_r  <= s_load_nxt;
      oq_cnt_r  <= oq_cnt_nxt;
      if (push) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_res_r <= s_res_nxt;
    if (push) begin
      oq[oq_wr_r] <= push_res;
    end
  end

  assign out_tvalid = (oq_cnt_r != '0);
  assign out_tdata  = oq[oq_rd_r];

  tbe_tape_store #(
    .TAPE_CELLS (TAPE_CELLS),
    .CELL_BITS  (CELL_BITS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (mem_busy)
  );

endmodule

FILE: src/tbe_checker.sv
// ----------------------------------------------------------------------------
// tbe_checker
// Port-level checks of the tape bytecode executor, bound to the top level.
// ----------------------------------------------------------------------------
module tbe_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [tbe_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tbe_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import tbe_pkg::*;

  res_t res;
  assign res = out_tdata;

  // A waiting result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The tape is being cleared right after reset, so no word is taken.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during the clearing sweep");

  // An illegal instruction leaves the counter where it ran, below the end.
  a_illegal_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.illegal |-> !res.halted && res.out_repeat == '0
                                  && res.in_consume == '0)
    else $error("illegal word with side effects or halt");

  // Output and input counts come from different instructions.
  a_one_io_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.out_repeat == '0 || res.in_consume == '0)
    else $error("result reports both output and input");

  // The input word is only sampled by its handshake; keep it observed.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !$isunknown(in_tdata[OPC_W-1:0]))
    else $error("unknown opcode accepted");

endmodule

bind tape_bytecode_executor tbe_checker u_tbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
